FILE: rtl/tcbd_pkg.sv
package tcbd_pkg;

  localparam int NUM_BOARDS      = 12;
  localparam int UNITS_PER_BOARD = 4;
  localparam int MAX_CANDIDATES  = 2;
  localparam int PAD_TOTAL       = (UNITS_PER_BOARD + 1) * MAX_CANDIDATES;

  localparam logic [1:0] VERSION_OLD = 2'd1;
  localparam logic [1:0] VERSION_RESET = 2'd2;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_BXID    = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_CAND    = 3'd3;
  localparam logic [2:0] KIND_PAD     = 3'd4;
  localparam logic [2:0] KIND_PREFIX  = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  localparam logic [1:0] BANK_OK        = 2'd0;
  localparam logic [1:0] BANK_TRUNCATED = 2'd1;
  localparam logic [1:0] BANK_FORMAT    = 2'd2;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_BXID   = 3'd2;
  localparam logic [2:0] PH_STATUS = 3'd3;
  localparam logic [2:0] PH_CAND   = 3'd4;
  localparam logic [2:0] PH_PAD    = 3'd5;

  localparam logic [31:0] MASK_HEADER = 32'hE000E000;
  localparam logic [31:0] MASK_BXID   = 32'hFF000000;
  localparam logic [31:0] MASK_STATUS = 32'h7F000000;
  localparam logic [31:0] MASK_CAND   = 32'hC0008000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  board;
    logic [2:0]  unit;
    logic        slot;
    logic [31:0] payload;
    logic [11:0] event_id;
    logic [11:0] bunch_id;
    logic [4:0]  status_errors;
    logic        reserved_error;
    logic        board_done;
    logic        bank_done;
    logic [1:0]  bank_status;
  } out_word_t;

  typedef struct packed {
    logic [3:0] board_index;
    logic [2:0] phase;
    logic [2:0] unit_index;
    logic [1:0] slot_index;
    logic [9:0] unit_counts;
    logic       compressed_flag;
    logic [3:0] padding_left;
    logic       error_seen;
    logic       bank_finished;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    board_index: 4'd0, phase: PH_START, unit_index: 3'd0, slot_index: 2'd0,
    unit_counts: 10'd0, compressed_flag: 1'b0, padding_left: 4'd0,
    error_seen: 1'b0, bank_finished: 1'b0
  };

  function automatic logic [1:0] clip_count(input logic [1:0] n);
    clip_count = (n > 2'(MAX_CANDIDATES)) ? 2'(MAX_CANDIDATES) : n;
  endfunction

  function automatic logic [1:0] count_of(input logic [9:0] counts, input logic [2:0] u);
    count_of = (u > 3'(UNITS_PER_BOARD)) ? 2'd0 : counts[2*u +: 2];
  endfunction

endpackage

FILE: rtl/tcbd_decode.sv
module tcbd_decode
  import tcbd_pkg::*;
(
  input  dec_state_t st,
  input  logic [1:0] bank_version,
  input  in_word_t   in_item,
  output dec_state_t st_next,
  output out_word_t  result
);

  logic        v1;
  logic        complete;
  logic        res;
  logic [31:0] w;
  logic [3:0]  nib;
  logic [1:0]  n;
  logic [1:0]  lim;
  logic [2:0]  slot_inc;
  logic [2:0]  next_unit;
  logic        found;
  logic [3:0]  pl;
  logic [3:0]  pos;

  assign v1 = (bank_version == VERSION_OLD);
  assign w  = in_item.word;

  always_comb begin
    st_next   = st;
    result    = '0;
    complete  = 1'b0;
    res       = 1'b0;
    nib       = '0;
    n         = '0;
    lim       = '0;
    slot_inc  = '0;
    next_unit = '0;
    found     = 1'b0;
    pl        = '0;
    pos       = '0;
    result.payload = w;
    result.kind    = KIND_IGNORED;

    if (st.bank_finished) begin
      if (in_item.last) begin
        st_next = STATE_RESET;
      end
    end else begin
      result.board = st.board_index;
      case (st.phase)
        PH_START, PH_HEADER: begin
          result.event_id = w[11:0];
          result.bunch_id = w[27:16];
          if (st.phase == PH_START && v1) begin
            result.kind   = KIND_PREFIX;
            st_next.phase = PH_STATUS;
          end else begin
            result.kind   = KIND_HEADER;
            res           = !v1 && ((w & MASK_HEADER) != '0);
            st_next.phase = v1 ? PH_STATUS : PH_BXID;
          end
        end
        PH_BXID: begin
          result.kind   = KIND_BXID;
          res           = !v1 && ((w & MASK_BXID) != '0);
          st_next.phase = PH_STATUS;
        end
        PH_STATUS: begin
          result.kind = KIND_STATUS;
          result.status_errors[0] = (w[3:0] > 4'd2);
          st_next.unit_counts = '0;
          st_next.unit_counts[1:0] = clip_count(w[1:0]);
          for (int u = 0; u < UNITS_PER_BOARD; u++) begin
            nib = w[4+4*u +: 4];
            result.status_errors[u+1] = (nib > 4'd2);
            st_next.unit_counts[2*u+2 +: 2] = clip_count(nib[1:0]);
          end
          st_next.compressed_flag = v1 ? 1'b1 : w[31];
          res = !v1 && ((w & MASK_STATUS) != '0);
          if (clip_count(w[1:0]) == 2'd0) begin
            if (st_next.compressed_flag) begin
              complete = 1'b1;
            end else begin
              st_next.padding_left = 4'(PAD_TOTAL);
              st_next.phase        = PH_PAD;
            end
          end else begin
            st_next.unit_index = '0;
            st_next.slot_index = '0;
            st_next.phase      = PH_CAND;
          end
        end
        PH_CAND: begin
          result.unit = st.unit_index;
          result.slot = st.slot_index[0];
          n = count_of(st.unit_counts, st.unit_index);
          if (st.slot_index < n) begin
            result.kind = KIND_CAND;
            res = !v1 && ((w & MASK_CAND) != '0);
          end else begin
            result.kind = KIND_PAD;
          end
          slot_inc = {1'b0, st.slot_index} + 3'd1;
          lim = st.compressed_flag ? n : 2'(MAX_CANDIDATES);
          if (slot_inc >= {1'b0, lim}) begin
            st_next.slot_index = '0;
            for (int k = 1; k <= UNITS_PER_BOARD; k++) begin
              if (!found && (3'(k) > st.unit_index) &&
                  (!st.compressed_flag || count_of(st.unit_counts, 3'(k)) != 2'd0)) begin
                next_unit = 3'(k);
                found     = 1'b1;
              end
            end
            if (found) begin
              st_next.unit_index = next_unit;
            end else begin
              complete = 1'b1;
            end
          end else begin
            st_next.slot_index = slot_inc[1:0];
          end
        end
        default: begin
          result.kind = KIND_PAD;
          pl = (st.padding_left > 4'(PAD_TOTAL)) ? 4'(PAD_TOTAL) : st.padding_left;
          if (pl == 4'd0) begin
            complete = 1'b1;
            st_next.padding_left = '0;
          end else begin
            pos = 4'(PAD_TOTAL) - pl;
            result.unit = 3'(pos / MAX_CANDIDATES);
            result.slot = 1'(pos % MAX_CANDIDATES);
            st_next.padding_left = pl - 4'd1;
            if (pl == 4'd1) begin
              complete = 1'b1;
            end
          end
        end
      endcase

      result.reserved_error = res;
      st_next.error_seen = st.error_seen | res;

      if (complete) begin
        result.board_done = 1'b1;
        if (st.board_index >= 4'(NUM_BOARDS - 1)) begin
          result.bank_done   = 1'b1;
          result.bank_status = st_next.error_seen ? BANK_FORMAT : BANK_OK;
          if (in_item.last) begin
            st_next = STATE_RESET;
          end else begin
            st_next.bank_finished = 1'b1;
          end
        end else begin
          st_next.board_index = st.board_index + 4'd1;
          st_next.phase       = PH_HEADER;
          if (in_item.last) begin
            result.bank_done   = 1'b1;
            result.bank_status = BANK_TRUNCATED;
            st_next            = STATE_RESET;
          end
        end
      end else if (in_item.last) begin
        result.bank_done   = 1'b1;
        result.bank_status = BANK_TRUNCATED;
        st_next            = STATE_RESET;
      end
    end
  end

endmodule

FILE: rtl/tcbd_outbuf.sv
module tcbd_outbuf
  import tcbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  out_word_t   entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/trigger_candidate_bank_deframer_unit.sv
// Trigger bank deframer: takes one 32-bit bank word per clock while in_stall is
// low and gives one labelled word for each, tagged with board, unit and slot,
// with header fields, status checks, reserved-bit errors and end-of-bank status.
// The single decode step feeds a two-entry output buffer that registers each
// word; one word a clock is sustained while out_stall is low, and in_stall is
// high only while both entries are occupied. bank_version resets to 2; the user
// must write it through the cfg port only between banks, unchecked by the block.
module trigger_candidate_bank_deframer_unit
  import tcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  dec_state_t st;
  dec_state_t st_next;
  out_word_t  result;
  logic [1:0] bank_version;
  logic       accept;
  logic       full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_version <= VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bank_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  tcbd_decode u_decode (
    .st           (st),
    .bank_version (bank_version),
    .in_item      (in_data),
    .st_next      (st_next),
    .result       (result)
  );

  tcbd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/tcbd_checker.sv
module tcbd_checker
  import tcbd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input out_word_t  out_data
);

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bank_status != BANK_OK |-> out_data.bank_done)
    else $error("bank status without bank end");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_IGNORED |->
      out_data.board_done == 1'b0 && out_data.bank_done == 1'b0 &&
      out_data.reserved_error == 1'b0 && out_data.board == 4'd0)
    else $error("ignored word carries flags");

  a_reserved_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reserved_error |->
      out_data.kind == KIND_HEADER || out_data.kind == KIND_BXID ||
      out_data.kind == KIND_STATUS || out_data.kind == KIND_CAND)
    else $error("reserved error on a word without reserved bits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind trigger_candidate_bank_deframer_unit tcbd_checker u_tcbd_checker (.*);

FILE: tb/sv/tb_trigger_candidate_bank_deframer_unit.sv
module tb_trigger_candidate_bank_deframer_unit
  import tcbd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1550;
  localparam int TAIL_ITEMS     = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = VERSION_RESET;

  trigger_candidate_bank_deframer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  out_word_t oldest;

  int   n_queued = 0;
  int   n_bad = 0;
  int   idle_odds = 5;
  int   stall_odds = 5;
  int   dirt_odds = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  // decoder walk state
  logic [1:0] pred_version;
  logic [3:0] walk_board;
  logic [2:0] walk_phase;
  logic [2:0] walk_unit;
  logic [1:0] walk_slot;
  logic [9:0] walk_counts;
  logic       walk_compressed;
  logic [3:0] walk_pad_left;
  logic       walk_err;
  logic       walk_finished;

  function automatic void rearm_walk();
    walk_board      = '0;
    walk_phase      = PH_START;
    walk_unit       = '0;
    walk_slot       = '0;
    walk_counts     = '0;
    walk_compressed = 1'b0;
    walk_pad_left   = '0;
    walk_err        = 1'b0;
    walk_finished   = 1'b0;
  endfunction

  function automatic logic [1:0] cap_count(input logic [1:0] n);
    if (n > MAX_CANDIDATES) return 2'(MAX_CANDIDATES);
    return n;
  endfunction

  function automatic logic [1:0] unit_count(input logic [2:0] u);
    if (u > UNITS_PER_BOARD) return 2'd0;
    return walk_counts[2*u +: 2];
  endfunction

  function automatic out_word_t decode_word(input in_word_t iw);
    out_word_t  r;
    logic       old_layout;
    logic       done_board;
    logic [1:0] n;
    logic [1:0] lim;
    logic [2:0] u;
    logic [3:0] nib;
    logic [3:0] pos;
    r = '0;
    r.kind = KIND_IGNORED;
    r.payload = iw.word;
    old_layout = (pred_version == VERSION_OLD);
    done_board = 1'b0;
    if (walk_finished) begin
      if (iw.last) rearm_walk();
    end else begin
      r.board = walk_board;
      if (walk_phase == PH_START && old_layout) begin
        r.kind = KIND_PREFIX;
        r.event_id = iw.word[11:0];
        r.bunch_id = iw.word[27:16];
        walk_phase = PH_STATUS;
      end else if (walk_phase == PH_START || walk_phase == PH_HEADER) begin
        r.kind = KIND_HEADER;
        r.event_id = iw.word[11:0];
        r.bunch_id = iw.word[27:16];
        r.reserved_error = !old_layout && |(iw.word & MASK_HEADER);
        walk_phase = old_layout ? PH_STATUS : PH_BXID;
      end else if (walk_phase == PH_BXID) begin
        r.kind = KIND_BXID;
        r.reserved_error = !old_layout && |(iw.word & MASK_BXID);
        walk_phase = PH_STATUS;
      end else if (walk_phase == PH_STATUS) begin
        r.kind = KIND_STATUS;
        r.status_errors[0] = iw.word[3:0] > 4'd2;
        walk_counts = '0;
        walk_counts[1:0] = cap_count(iw.word[1:0]);
        for (int k = 0; k < UNITS_PER_BOARD; k++) begin
          nib = iw.word[4+4*k +: 4];
          r.status_errors[k+1] = nib > 4'd2;
          walk_counts[2*(k+1) +: 2] = cap_count(nib[1:0]);
        end
        walk_compressed = old_layout | iw.word[31];
        r.reserved_error = !old_layout && |(iw.word & MASK_STATUS);
        if (walk_counts[1:0] == 2'd0) begin
          if (walk_compressed) begin
            done_board = 1'b1;
          end else begin
            walk_pad_left = 4'(PAD_TOTAL);
            walk_phase = PH_PAD;
          end
        end else begin
          walk_unit = '0;
          walk_slot = '0;
          walk_phase = PH_CAND;
        end
      end else if (walk_phase == PH_CAND) begin
        r.unit = walk_unit;
        r.slot = walk_slot[0];
        n = unit_count(walk_unit);
        if (walk_slot < n) begin
          r.kind = KIND_CAND;
          r.reserved_error = !old_layout && |(iw.word & MASK_CAND);
        end else begin
          r.kind = KIND_PAD;
        end
        walk_slot = walk_slot + 2'd1;
        lim = walk_compressed ? n : 2'(MAX_CANDIDATES);
        if (walk_slot >= lim) begin
          u = walk_unit + 3'd1;
          walk_slot = '0;
          if (walk_compressed)
            while (u <= UNITS_PER_BOARD && unit_count(u) == 2'd0) u = u + 3'd1;
          if (u > UNITS_PER_BOARD) done_board = 1'b1;
          else walk_unit = u;
        end
      end else begin
        r.kind = KIND_PAD;
        if (walk_pad_left > PAD_TOTAL) walk_pad_left = 4'(PAD_TOTAL);
        if (walk_pad_left == 4'd0) begin
          done_board = 1'b1;
        end else begin
          pos = 4'(PAD_TOTAL) - walk_pad_left;
          r.unit = 3'(pos / MAX_CANDIDATES);
          r.slot = 1'(pos % MAX_CANDIDATES);
          walk_pad_left = walk_pad_left - 4'd1;
          if (walk_pad_left == 4'd0) done_board = 1'b1;
        end
      end

      walk_err = walk_err | r.reserved_error;
      r.board_done = done_board;
      if (done_board) begin
        if (walk_board >= NUM_BOARDS - 1) begin
          r.bank_done = 1'b1;
          r.bank_status = walk_err ? BANK_FORMAT : BANK_OK;
          if (iw.last) rearm_walk();
          else walk_finished = 1'b1;
        end else begin
          walk_board = walk_board + 4'd1;
          walk_phase = PH_HEADER;
          if (iw.last) begin
            r.bank_done = 1'b1;
            r.bank_status = BANK_TRUNCATED;
            rearm_walk();
          end
        end
      end else if (iw.last) begin
        r.bank_done = 1'b1;
        r.bank_status = BANK_TRUNCATED;
        rearm_walk();
      end
    end
    return r;
  endfunction

  function automatic string word_text(input out_word_t o);
    return $sformatf({"kind %0d board %0d unit %0d slot %0d word %h ev %h bx %h ",
                      "st %b res %b bd %b bk %b bs %0d"},
                     o.kind, o.board, o.unit, o.slot, o.payload, o.event_id,
                     o.bunch_id, o.status_errors, o.reserved_error, o.board_done,
                     o.bank_done, o.bank_status);
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  function automatic logic [31:0] soil(input logic [31:0] clean, input logic [31:0] mask);
    if (dirt_odds != 0 && $urandom_range(1, dirt_odds) == 1) return clean | ($urandom() & mask);
    return clean;
  endfunction

  function automatic logic [31:0] random_status();
    logic [31:0] s;
    s = $urandom();
    for (int u = 0; u <= UNITS_PER_BOARD; u++)
      s[4*u +: 4] = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
    return soil(s & ~MASK_STATUS, MASK_STATUS);
  endfunction

  task automatic push_word(input logic [31:0] w, input logic l);
    in_word_t iw;
    iw.word = w;
    iw.last = l;
    pending_words.insert(pending_words.size(), iw);
    n_queued++;
  endtask

  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++)
      push_word($urandom(), (k == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  task automatic queue_bank(input logic old_layout);
    logic [31:0] words[$];
    logic [31:0] st;
    int          body;
    int          n_send;
    int          tail;
    int          mode;
    for (int b = 0; b < NUM_BOARDS; b++) begin
      if (old_layout) begin
        words.insert(words.size(), $urandom());
      end else begin
        words.insert(words.size(), soil($urandom() & ~MASK_HEADER, MASK_HEADER));
        words.insert(words.size(), soil($urandom() & ~MASK_BXID, MASK_BXID));
      end
      st = random_status();
      words.insert(words.size(), st);
      body = 0;
      if (!old_layout && !st[31]) begin
        body = PAD_TOTAL;
      end else if (cap_count(st[1:0]) != 2'd0) begin
        for (int u = 0; u <= UNITS_PER_BOARD; u++) body += cap_count(st[4*u +: 2]);
      end
      for (int k = 0; k < body; k++)
        words.insert(words.size(), soil($urandom() & ~MASK_CAND, MASK_CAND));
    end
    n_send = words.size();
    tail = 0;
    mode = $urandom_range(0, 9);
    if (mode < 2) n_send = $urandom_range(1, words.size());
    else if (mode < 4) tail = $urandom_range(1, 6);
    for (int k = 0; k < n_send; k++) push_word(words[k], k == n_send - 1 && tail == 0);
    for (int k = 0; k < tail; k++) push_word($urandom(), k == tail - 1);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred_version = v;
    @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // sender: hold while stalled, otherwise idle in bursts or offer the next word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_words.insert(expected_words.size(), decode_word(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 16);
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted word against the oldest decoded one and drive out_stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (n_bad < 10) $display("unexpected word: %s", word_text(out_data));
          n_bad <= n_bad + 1;
        end else begin
          oldest = expected_words.pop_front();
          if (out_data !== oldest) begin
            if (n_bad < 10)
              $display("mismatch: expected %s, got %s", word_text(oldest), word_text(out_data));
            n_bad <= n_bad + 1;
          end
        end
      end
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    pred_version = VERSION_RESET;
    rearm_walk();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // current layout: dirty header, padded board, truncate on next header
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    for (int k = 0; k < PAD_TOTAL; k++) push_word(k[0] ? 32'hFFFF_FFFF : 32'h0, 1'b0);
    push_word(32'h0000_0000, 1'b1);
    wait_idle();

    // old layout, then switch to the current one mid-board
    write_version(VERSION_OLD);
    push_word(32'h0FFF_0FFF, 1'b0);
    push_word(32'hFF00_0033, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    wait_idle();
    write_version(VERSION_RESET);
    push_word(32'hC000_8000, 1'b0);
    push_word(32'h0000_0001, 1'b0);
    push_word(32'h3FFF_7FFF, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h1234_5678, 1'b1);
    wait_idle();

    phase_no = 0;
    while (n_queued + TAIL_ITEMS < ITEM_TARGET) begin
      write_version(($urandom_range(0, 1) == 1) ? VERSION_OLD : VERSION_RESET);
      idle_odds = pick_odds();
      stall_odds = pick_odds();
      repeat (2) begin
        dirt_odds = ($urandom_range(0, 1) == 1) ? 0 : 40;
        queue_bank(pred_version == VERSION_OLD);
        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(3, 20));
      end
      if (phase_no == 1) hold_req = 1'b1;
      wait_idle();
      phase_no++;
    end

    // run the tail flat out
    idle_odds = 0;
    stall_odds = 0;
    write_version(VERSION_RESET);
    dirt_odds = 0;
    queue_bank(1'b0);
    queue_bank(1'b0);
    wait_idle();
    @(negedge clk);

    if (n_bad == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
